@@ sv/int2asc_pkg.sv @@
// Shared types and constants for the integer to ASCII radix converter.
// Depends on nothing; imported by integer_to_ascii_radix.
`default_nettype none

package int2asc_pkg;

    // One number to convert.
    typedef struct packed {
        logic [63:0] value;
        logic        is_wide;
        logic        is_signed;
        logic [1:0]  radix_code;
    } number_t;

    // One output character.
    typedef struct packed {
        logic [7:0] ascii_char;
        logic       last_char;
    } text_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_EMIT
    } state_t;

    // Radix select codes; the spare code behaves as hex.
    localparam logic [1:0] RADIX_OCT = 2'd0;
    localparam logic [1:0] RADIX_DEC = 2'd1;
    localparam logic [1:0] RADIX_HEX = 2'd2;

    // Decimal long division takes one 16-bit chunk per cycle. With a remainder
    // below ten in front, the dividend is 20 bits, and multiplying by
    // ceil(2^23 / 10) and shifting by 23 gives the exact quotient.
    localparam int          CHUNK_W     = 16;
    localparam int          DEC_X_W     = 20;
    localparam int          DEC_PROD_W  = 40;
    localparam int          DIV10_SHIFT = 23;
    localparam logic [19:0] DIV10_MUL   = 20'd838861;
    localparam logic [3:0]  DEC_BASE    = 4'd10;

    localparam logic [7:0] CHAR_MINUS  = 8'h2d;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;

    // Lower-case digit character for a digit value of 0 to 15.
    function automatic logic [7:0] digit_char(input logic [3:0] digit);
        logic [7:0] ch;
        if (digit < DEC_BASE) begin
            ch = CHAR_ZERO + {4'd0, digit};
        end
        else begin
            ch = CHAR_LOWER_A + {4'd0, digit - DEC_BASE};
        end
        return ch;
    endfunction

endpackage

`default_nettype wire

@@ sv/integer_to_ascii_radix.sv @@
// Integer to ASCII radix converter: magnitude, digit extraction, character output.
// Depends on int2asc_pkg for the channel structs, the state type and constants.
//
//  Channel   Signals                           Direction  Contents
//  number    number_valid/number_stall/number  in         value, widths, sign, radix
//  text      text_valid/text_stall/text        out        one character, last mark
//
// A number is accepted in ST_IDLE, which also forms its magnitude. Octal and hex
// then shift out a 3- or 4-bit digit per step; decimal divides by ten over all
// NCHUNK chunks per digit (NCHUNK = VALUE_WIDTH/16 rounded up, 4 by default), one
// pass of the shared 20 x 20 reciprocal multiplier per 16-bit chunk. Characters
// then leave one per cycle from the output register while text is not stalled.
// The number channel is stalled from the cycle after acceptance until the last
// character has been loaded into the output register.
// Reset clears all control state; the digit store holds no reset value.
// A stall on the text channel holds the output register and pauses emission.
`default_nettype none

module integer_to_ascii_radix
    import int2asc_pkg::*;
#(
    parameter int MAX_DIGITS  = 22,
    parameter int VALUE_WIDTH = 64
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    number_valid,
    output logic         number_stall,
    input  wire number_t number,
    output logic         text_valid,
    input  wire logic    text_stall,
    output text_t        text
);

    // The work register is a whole number of 16-bit chunks so that decimal
    // long division can rotate through it.
    localparam int NCHUNK = (VALUE_WIDTH + CHUNK_W - 1) / CHUNK_W;
    localparam int WORK_W = NCHUNK * CHUNK_W;
    localparam int CHK_W  = $clog2(NCHUNK);
    localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W  = $clog2(MAX_DIGITS);

    state_t               state_reg, state_next;
    logic [WORK_W-1:0]    work_reg, work_next;
    logic [3:0]           rem_reg, rem_next;
    logic [CHK_W-1:0]     chunk_reg, chunk_next;
    logic [1:0]           radix_reg, radix_next;
    logic                 neg_reg, neg_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     ptr_reg, ptr_next;
    logic                 text_valid_reg, text_valid_next;
    text_t                text_reg, text_next;

    // Digit store: written at the digit count, read one below the emit pointer.
    logic [3:0]           store_reg [MAX_DIGITS];
    logic                 store_we;
    logic [IDX_W-1:0]     store_waddr;
    logic [3:0]           store_wdata;

    // Operand and magnitude on acceptance.
    logic [VALUE_WIDTH-1:0] operand;
    logic [VALUE_WIDTH-1:0] magnitude;
    logic [31:0]            mag_narrow;
    logic [VALUE_WIDTH-1:0] mag_wide;
    logic                   sign_bit;

    // Decimal chunk step.
    logic [DEC_X_W-1:0]    dec_x;
    logic [DEC_PROD_W-1:0] dec_prod;
    logic [CHUNK_W-1:0]    dec_q;
    logic [DEC_X_W-1:0]    dec_q10;
    logic [DEC_X_W-1:0]    dec_diff;
    logic [3:0]            dec_r;

    logic                  digit_valid;
    logic [3:0]            digit;
    logic [CNT_W-1:0]      count_inc;
    logic [CNT_W-1:0]      ptr_dec;
    logic                  text_taken;
    logic                  load;

    assign operand  = number.is_wide ? number.value[VALUE_WIDTH-1:0]
                                     : VALUE_WIDTH'(number.value[31:0]);
    assign sign_bit = number.is_wide ? number.value[VALUE_WIDTH-1] : number.value[31];
    assign mag_narrow = ~number.value[31:0] + 32'd1;
    assign mag_wide   = ~number.value[VALUE_WIDTH-1:0] + VALUE_WIDTH'(1);
    // The most negative value wraps to itself, which read unsigned is its magnitude.
    assign magnitude  = (number.is_signed && sign_bit)
                        ? (number.is_wide ? mag_wide : VALUE_WIDTH'(mag_narrow))
                        : operand;

    assign dec_x    = {rem_reg, work_reg[WORK_W-1 -: CHUNK_W]};
    assign dec_prod = DEC_PROD_W'(dec_x) * DEC_PROD_W'(DIV10_MUL);
    assign dec_q    = dec_prod[DIV10_SHIFT +: CHUNK_W];
    assign dec_q10  = DEC_X_W'({dec_q, 3'b000}) + DEC_X_W'({dec_q, 1'b0});
    assign dec_diff = dec_x - dec_q10;
    assign dec_r    = dec_diff[3:0];

    assign ptr_dec    = ptr_reg - CNT_W'(1);
    assign text_taken = text_valid_reg && !text_stall;

    always_comb
    begin
        state_next      = state_reg;
        work_next       = work_reg;
        rem_next        = rem_reg;
        chunk_next      = chunk_reg;
        radix_next      = radix_reg;
        neg_next        = neg_reg;
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        text_valid_next = text_valid_reg && !text_taken;
        text_next       = text_reg;
        store_we        = 1'b0;
        store_waddr     = count_reg[IDX_W-1:0];
        store_wdata     = 4'd0;
        digit_valid     = 1'b0;
        digit           = 4'd0;
        count_inc       = count_reg;
        load            = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (number_valid) begin
                    work_next  = WORK_W'(magnitude);
                    rem_next   = 4'd0;
                    chunk_next = '0;
                    count_next = '0;
                    radix_next = number.radix_code;
                    neg_next   = number.is_signed && sign_bit;
                    state_next = ST_DIVIDE;
                end
            end

            ST_DIVIDE:
            begin
                priority if (radix_reg == RADIX_DEC) begin
                    // Rotate the quotient chunk in at the bottom; after a full
                    // pass the register holds the quotient and the last remainder is the digit.
                    work_next = {work_reg[WORK_W-CHUNK_W-1:0], dec_q};
                    if (chunk_reg == CHK_W'(NCHUNK - 1)) begin
                        digit_valid = 1'b1;
                        digit       = dec_r;
                        rem_next    = 4'd0;
                        chunk_next  = '0;
                    end
                    else begin
                        rem_next   = dec_r;
                        chunk_next = chunk_reg + CHK_W'(1);
                    end
                end
                else if (radix_reg == RADIX_OCT) begin
                    work_next   = work_reg >> 3;
                    digit_valid = 1'b1;
                    digit       = {1'b0, work_reg[2:0]};
                end
                else begin
                    work_next   = work_reg >> 4;
                    digit_valid = 1'b1;
                    digit       = work_reg[3:0];
                end

                if (digit_valid) begin
                    // Digits beyond the store are dropped.
                    if (count_reg < CNT_W'(MAX_DIGITS)) begin
                        store_we    = 1'b1;
                        store_wdata = digit;
                        count_inc   = count_reg + CNT_W'(1);
                    end
                    count_next = count_inc;
                    if (work_next == '0) begin
                        ptr_next   = count_inc;
                        // No room for the sign when the digits fill the store.
                        neg_next   = neg_reg && (count_inc < CNT_W'(MAX_DIGITS));
                        state_next = ST_EMIT;
                    end
                end
            end

            ST_EMIT:
            begin
                load = !text_valid_reg || !text_stall;
                if (load) begin
                    text_valid_next = 1'b1;
                    if (neg_reg) begin
                        text_next.ascii_char = CHAR_MINUS;
                        text_next.last_char  = 1'b0;
                        neg_next             = 1'b0;
                    end
                    else begin
                        text_next.ascii_char = digit_char(store_reg[ptr_dec[IDX_W-1:0]]);
                        text_next.last_char  = (ptr_reg == CNT_W'(1));
                        ptr_next             = ptr_dec;
                        if (ptr_reg == CNT_W'(1)) begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg      <= ST_IDLE;
            work_reg       <= '0;
            rem_reg        <= 4'd0;
            chunk_reg      <= '0;
            radix_reg      <= RADIX_OCT;
            neg_reg        <= 1'b0;
            count_reg      <= '0;
            ptr_reg        <= '0;
            text_valid_reg <= 1'b0;
        end
        else begin
            state_reg      <= state_next;
            work_reg       <= work_next;
            rem_reg        <= rem_next;
            chunk_reg      <= chunk_next;
            radix_reg      <= radix_next;
            neg_reg        <= neg_next;
            count_reg      <= count_next;
            ptr_reg        <= ptr_next;
            text_valid_reg <= text_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        text_reg <= text_next;
        if (store_we) begin
            store_reg[store_waddr] <= store_wdata;
        end
    end

    assign number_stall = (state_reg != ST_IDLE);
    assign text_valid   = text_valid_reg;
    assign text         = text_reg;

    // The digit count never runs past the store.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_DIGITS))
    else $error("digit count exceeds the digit store");

    // A decimal partial remainder is always a single digit.
    assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg < DEC_BASE)
    else $error("decimal remainder out of range");

    // Emission always has at least one digit left to send.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (ptr_reg != '0))
    else $error("emit pointer empty while emitting");

    // Entering emission follows a digit step that left a zero quotient.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVIDE && state_next == ST_EMIT) |=> (work_reg == '0))
    else $error("emission started with digits still to extract");

endmodule

`default_nettype wire
